FILE: rtl/arfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfd_pkg
// Shared types, constants and helper functions for the accessory remote
// frame decoder.
// ----------------------------------------------------------------------------
package arfd_pkg;

	// Number of payload bytes that a frame keeps (the rest are skipped).
	localparam int KEPT_BYTES = 5;

	// Frame position codes; positions from POS_BODY up walk the frame body.
	localparam logic [8:0] POS_HUNT = 9'd0;
	localparam logic [8:0] POS_FF   = 9'd1;
	localparam logic [8:0] POS_LEN  = 9'd2;
	localparam logic [8:0] POS_MODE = 9'd3;
	localparam logic [8:0] POS_BODY = 9'd4;

	// Header and reply framing bytes.
	localparam logic [7:0] HDR_SYNC  = 8'hff;
	localparam logic [7:0] HDR_START = 8'h55;
	localparam logic [7:0] REPLY_LEN = 8'h03;
	localparam logic [7:0] REPLY_CMD = 8'h04;

	// Mode-switch commands.
	localparam logic [7:0] CMD_SET    = 8'h01;
	localparam logic [7:0] CMD_QUERY  = 8'h03;
	localparam logic [7:0] CMD_AIR    = 8'h05;
	localparam logic [7:0] CMD_SIMPLE = 8'h06;

	// Configuration register indexes.
	localparam logic [1:0] REG_SWITCH = 2'd0;
	localparam logic [1:0] REG_SIMPLE = 2'd1;
	localparam logic [1:0] REG_AIR    = 2'd2;

	// Index of the last beat of the seven-beat reply frame.
	localparam logic [2:0] REPLY_LAST = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [7:0] RST_SWITCH = 8'd0;
	localparam logic [7:0] RST_SIMPLE = 8'd2;
	localparam logic [7:0] RST_AIR    = 8'd4;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_AIR     = 2'd2,
		EV_TX      = 2'd3
	} event_kind_t;

	// What a finished frame produces.
	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_EVENT = 2'd1,
		RES_REPLY = 2'd2
	} res_class_t;

	// Byte of the mode reply frame at beat index idx.
	function automatic logic [7:0] reply_byte(input logic [2:0] idx,
		input logic [7:0] sw, input logic [7:0] cm);
		logic [7:0] sum;
		logic [7:0] res;
		sum = REPLY_LEN + sw + REPLY_CMD + cm;
		case (idx)
			3'd0: res = HDR_SYNC;
			3'd1: res = HDR_START;
			3'd2: res = REPLY_LEN;
			3'd3: res = sw;
			3'd4: res = REPLY_CMD;
			3'd5: res = cm;
			default: res = 8'd0 - sum;
		endcase
		return res;
	endfunction

endpackage

FILE: rtl/accessory_remote_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accessory_remote_frame_decoder
// Parses FF 55 framed accessory packets from a received byte stream and
// reports button, AiR and mode-switch events, plus mode reply bytes.
// ----------------------------------------------------------------------------
// One received byte is taken per beat on the slave stream. A byte that ends
// no frame, or ends a frame that reports nothing, never waits in the input
// register, so such bytes stream at one per clock. The checksum byte of a
// frame yields one event beat or a run of seven reply beats; the output
// buffer holds that run and drains one beat per cycle while the receiver is
// ready. Only a byte whose frame yields results waits in the input register,
// until the buffer is empty or is handing over its last beat; every other
// byte moves on at once. The shortest frame with a result takes six bytes,
// fewer than the seven beats of a reply, so a result byte that follows a
// reply closely can wait even with the receiver always ready. The first
// result beat of a byte is offered from the output buffer, loaded as the
// byte leaves the input register. Each result beat carries the event kind
// on tuser and the value on tdata; tlast marks the final beat caused by one
// input byte. The user must set the three mode codes through the APB port
// only while the decoder is idle; the block does not enforce it.
module accessory_remote_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Received bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Events and reply bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] event_value
	output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
	output logic        m_axis_tlast    // last_of_run
);
	import arfd_pkg::*;

	// Configuration registers.
	logic [7:0] switch_code_q;
	logic [7:0] simple_code_q;
	logic [7:0] air_code_q;

	// Input register.
	logic       in_valid_s1;
	logic [7:0] rx_s1;

	// Frame state.
	logic [8:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] mode_q;
	logic [7:0] payload_q [KEPT_BYTES];
	logic [7:0] cur_mode_q;

	// Output buffer.
	logic        out_valid_q;
	logic        reply_q;
	logic [2:0]  idx_q;
	event_kind_t kind_q;
	logic [31:0] value_q;
	logic [7:0]  rsw_q;
	logic [7:0]  rcm_q;

	// Combinational results.
	logic        cfg_we;
	logic        advance;
	logic        buf_free;
	logic        out_last;
	logic        finishing;
	logic [8:0]  body_end;
	logic [7:0]  n;
	logic [8:0]  pos_d;
	logic [7:0]  cur_mode_d;
	res_class_t  res_cls;
	event_kind_t res_kind;
	logic [31:0] res_value;

	// APB access: always ready, write on the access phase.
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_SWITCH: prdata = {24'd0, switch_code_q};
			REG_SIMPLE: prdata = {24'd0, simple_code_q};
			REG_AIR:    prdata = {24'd0, air_code_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_code_q <= RST_SWITCH;
			simple_code_q <= RST_SIMPLE;
			air_code_q    <= RST_AIR;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_SWITCH: switch_code_q <= pwdata[7:0];
				REG_SIMPLE: simple_code_q <= pwdata[7:0];
				REG_AIR:    air_code_q    <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	// Handshake: the buffer is free when empty or when its last beat leaves now.
	assign out_last = ~reply_q | (idx_q == REPLY_LAST);
	assign buf_free = ~out_valid_q | (m_axis_tready & out_last);
	assign advance  = in_valid_s1 & ((res_cls == RES_NONE) | buf_free);
	assign s_axis_tready = ~in_valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_s1 <= s_axis_tdata;
		end
	end

	// Frame walker: next position and whether this byte is the checksum.
	assign body_end  = {1'b0, len_q} + 9'd3;
	assign finishing = (pos_q >= POS_BODY) && (pos_q >= body_end);
	assign n         = len_q - 8'd1;

	always_comb begin
		pos_d = pos_q;
		case (pos_q)
			POS_HUNT: begin
				if (rx_s1 == HDR_SYNC) pos_d = POS_FF;
			end
			POS_FF: begin
				if (rx_s1 == HDR_START) pos_d = POS_LEN;
				else if (rx_s1 != HDR_SYNC) pos_d = POS_HUNT;
			end
			POS_LEN:  pos_d = POS_MODE;
			POS_MODE: pos_d = (len_q == 8'd0) ? POS_HUNT : POS_BODY;
			default: begin
				if (finishing) pos_d = POS_HUNT;
				else pos_d = pos_q + 9'd1;
			end
		endcase
	end

	// Frame decode at the checksum byte.
	always_comb begin
		res_cls    = RES_NONE;
		res_kind   = EV_PRESS;
		res_value  = 32'd0;
		cur_mode_d = cur_mode_q;
		if (finishing) begin
			if (mode_q == switch_code_q) begin
				res_cls  = RES_REPLY;
				res_kind = EV_TX;
				case (payload_q[0])
					CMD_SET:    cur_mode_d = payload_q[1];
					CMD_AIR:    cur_mode_d = air_code_q;
					CMD_SIMPLE: cur_mode_d = simple_code_q;
					CMD_QUERY:  ;
					default:    res_cls = RES_NONE;
				endcase
			end else if (mode_q == simple_code_q) begin
				if (n >= 8'd2 && n <= 8'd5 && payload_q[0] == 8'd0) begin
					res_cls = RES_EVENT;
					if (n == 8'd2 && payload_q[1] == 8'd0) begin
						res_kind = EV_RELEASE;
					end else begin
						res_kind  = EV_PRESS;
						res_value = {(n > 8'd4) ? payload_q[4] : 8'd0,
							(n > 8'd3) ? payload_q[3] : 8'd0,
							(n > 8'd2) ? payload_q[2] : 8'd0,
							payload_q[1]};
					end
				end
			end else if (mode_q == air_code_q) begin
				if (n == 8'd2 && payload_q[0] == 8'd0) begin
					res_cls   = RES_EVENT;
					res_kind  = EV_AIR;
					res_value = {24'd0, payload_q[1]};
				end
			end
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_HUNT;
			len_q      <= 8'd0;
			mode_q     <= 8'd0;
			cur_mode_q <= RST_AIR;
			for (int i = 0; i < KEPT_BYTES; i++) payload_q[i] <= 8'd0;
		end else if (advance) begin
			pos_q      <= pos_d;
			cur_mode_q <= cur_mode_d;
			if (pos_q == POS_LEN) len_q <= rx_s1;
			if (pos_q == POS_MODE) mode_q <= rx_s1;
			for (int i = 0; i < KEPT_BYTES; i++) begin
				if (pos_q == POS_FF && rx_s1 == HDR_START) begin
					payload_q[i] <= 8'd0;
				end else if (!finishing && pos_q == POS_BODY + 9'(i)) begin
					payload_q[i] <= rx_s1;
				end
			end
		end
	end

	// Output buffer: one event beat or a seven-beat reply run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			reply_q     <= 1'b0;
			idx_q       <= 3'd0;
		end else if (advance && res_cls != RES_NONE) begin
			out_valid_q <= 1'b1;
			reply_q     <= (res_cls == RES_REPLY);
			idx_q       <= 3'd0;
		end else if (out_valid_q && m_axis_tready) begin
			if (out_last) out_valid_q <= 1'b0;
			else idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_cls != RES_NONE) begin
			kind_q  <= res_kind;
			value_q <= res_value;
			rsw_q   <= switch_code_q;
			rcm_q   <= cur_mode_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last;
	assign m_axis_tuser  = reply_q ? EV_TX : kind_q;
	assign m_axis_tdata  = reply_q ? {24'd0, reply_byte(idx_q, rsw_q, rcm_q)} : value_q;

`ifndef SYNTHESIS
	// A reply run never walks past its checksum beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && reply_q) |-> (idx_q <= REPLY_LAST))
		else $error("reply beat index out of range");

	// A new result never overwrites a run that is still being delivered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !(m_axis_tready && out_last)) |-> !(advance && res_cls != RES_NONE))
		else $error("output buffer overwritten");

	// The frame position stays within the longest possible frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 9'd258)
		else $error("frame position out of range");

	// Back-pressure on the input only comes from a held byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (in_valid_s1 && out_valid_q))
		else $error("input stalled without cause");
`endif

endmodule
